// ----- src/cbe_pkg.sv -----
// shared types and curve constants for the cubic bezier easing block
package cbe_pkg;

   typedef enum logic [2:0] {
      CURVE_LINEAR = 3'd0,
      CURVE_STANDARD = 3'd1,
      CURVE_DECEL = 3'd2,
      CURVE_ACCEL = 3'd3,
      CURVE_SHARP = 3'd4
   } curve_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START,
      ST_EVAL,
      ST_NEWTON_CHK,
      ST_DIVIDE,
      ST_NEWTON_UPD,
      ST_BISECT_CHK,
      ST_FINAL,
      ST_DONE
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic load;
      logic eval_start;
      logic eval_y;
      logic div_start;
      logic newton_upd;
      logic bisect_upd;
      logic final_load;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic linear;
      logic eval_done;
      logic div_done;
      logic slope_flat;
      logic hit;
   } sts_type;

endpackage

// ----- src/cubic_bezier_easing_curve.sv -----
// cubic bezier easing curve: top level
// a linear curve passes progress straight to the result; other curves run a
// bezier evaluation and a serial newton divide per newton step, then
// bisection steps and a final evaluation of y;
// one item at a time, next word taken the cycle after the result is registered;
// a pending result waits in the output register. synchronous reset, none pending
module cubic_bezier_easing_curve #(
   parameter int NEWTON_STEPS = 6,
   parameter int BISECT_STEPS = 8,
   parameter int FRAC_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [2:0] req_curve,
   input  logic [FRAC_BITS:0] req_progress,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [FRAC_BITS:0] rsp_eased
);
   cbe_pkg::cmd_type cmd;
   cbe_pkg::sts_type sts;

   cbe_ctrl #(.NEWTON_STEPS(NEWTON_STEPS), .BISECT_STEPS(BISECT_STEPS)) u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .sts(sts), .cmd(cmd)
   );

   cbe_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .req_curve(req_curve), .req_progress(req_progress), .result(rsp_eased)
   );
endmodule

// ----- src/cbe_datapath.sv -----
// datapath: shared multiplier for bezier evaluation, serial divider, t update
module cbe_datapath #(
   parameter int FRAC_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  cbe_pkg::cmd_type cmd,
   output cbe_pkg::sts_type sts,
   input  logic [2:0] req_curve,
   input  logic [FRAC_BITS:0] req_progress,
   output logic [FRAC_BITS:0] result
);
   localparam int W = FRAC_BITS + 1;
   localparam int SW = FRAC_BITS + 6;   // signed working width
   localparam int PW = 2 * SW;
   localparam int DW = FRAC_BITS + 24;  // dividend width (err << FRAC_BITS)
   localparam int DCW = $clog2(DW + 1);
   localparam logic signed [SW-1:0] ONE = SW'(1) <<< FRAC_BITS;
   localparam logic signed [SW-1:0] HALF = SW'(1) <<< (FRAC_BITS - 1);
   localparam logic signed [SW-1:0] CP2 = SW'((2 * (64'd1 << FRAC_BITS) + 5) / 10);
   localparam logic signed [SW-1:0] CP4 = SW'((4 * (64'd1 << FRAC_BITS) + 5) / 10);
   localparam logic signed [SW-1:0] CP6 = SW'((6 * (64'd1 << FRAC_BITS) + 5) / 10);

   // control point registers
   logic signed [SW-1:0] x1_ff, x1_in, x2_ff, x2_in, p_ff, p_in;
   logic linear_ff, linear_in;
   logic signed [SW-1:0] t_ff, t_in, lo_ff, lo_in, hi_ff, hi_in;

   always_comb begin
      logic [W-1:0] pc;
      pc = (req_progress > W'(1) << FRAC_BITS) ? (W'(1) << FRAC_BITS) : req_progress;
      p_in = SW'(pc);
      linear_in = 1'b0;
      x1_in = CP4;
      x2_in = CP2;
      unique case (req_curve)
         3'(cbe_pkg::CURVE_LINEAR): linear_in = 1'b1;
         3'(cbe_pkg::CURVE_DECEL): x1_in = '0;
         3'(cbe_pkg::CURVE_ACCEL): x2_in = ONE;
         3'(cbe_pkg::CURVE_SHARP): x2_in = CP6;
         default: ;
      endcase
   end

   // evaluation sequencer: one rounded product per cycle through a shared multiplier
   logic [3:0] ev_step_ff, ev_step_in;
   logic ev_busy_ff, ev_busy_in;
   logic ev_y_ff, ev_y_in;
   logic signed [SW-1:0] inv_ff, inv_in, ua_ff, ua_in, ub_ff, ub_in, uc_ff, uc_in;
   logic signed [SW-1:0] k0_ff, k0_in, k1_ff, k1_in, k2_ff, k2_in;
   logic signed [SW-1:0] pr_ff, pr_in;   // registered product
   logic signed [SW+3:0] xv_ff, xv_in, sv_ff, sv_in;
   logic signed [SW-1:0] ma, mb;
   logic signed [PW-1:0] prod;
   logic signed [PW-1:0] rnd;
   logic signed [SW-1:0] ca, cb;

   assign ca = ev_y_ff ? '0 : x1_ff;
   assign cb = ev_y_ff ? ONE : x2_ff;

   always_comb begin
      ma = '0;
      mb = '0;
      case (ev_step_ff)
         4'd1: begin ma = inv_ff; mb = inv_ff; end   // u
         4'd2: begin ma = inv_ff; mb = t_ff; end     // v
         4'd3: begin ma = t_ff;   mb = t_ff; end     // w
         4'd4: begin ma = ua_ff;  mb = t_ff; end     // k0
         4'd5: begin ma = ub_ff;  mb = t_ff; end     // k1
         4'd6: begin ma = uc_ff;  mb = t_ff; end     // k2
         4'd7: begin ma = k0_ff;  mb = ca; end
         4'd8: begin ma = k1_ff;  mb = cb; end
         4'd9: begin ma = k2_ff;  mb = ONE; end
         4'd10: begin ma = ua_ff; mb = ca; end
         4'd11: begin ma = ub_ff; mb = cb - ca; end
         4'd12: begin ma = uc_ff; mb = ONE - cb; end
         default: ;
      endcase
   end

   assign prod = ma * mb;
   assign rnd = (prod >= 0) ? ((prod + PW'(HALF)) >>> FRAC_BITS)
                            : -((-prod + PW'(HALF)) >>> FRAC_BITS);

   always_comb begin
      ev_step_in = ev_step_ff;
      ev_busy_in = ev_busy_ff;
      ev_y_in = ev_y_ff;
      inv_in = inv_ff;
      ua_in = ua_ff; ub_in = ub_ff; uc_in = uc_ff;
      k0_in = k0_ff; k1_in = k1_ff; k2_in = k2_ff;
      xv_in = xv_ff; sv_in = sv_ff;
      pr_in = SW'(rnd);
      if (cmd.eval_start) begin
         ev_busy_in = 1'b1;
         ev_step_in = 4'd1;
         ev_y_in = cmd.eval_y;
         inv_in = ONE - t_ff;
         xv_in = '0;
         sv_in = '0;
      end else if (ev_busy_ff) begin
         ev_step_in = ev_step_ff + 4'd1;
         // consume previous cycle's product
         case (ev_step_ff)
            4'd2: ua_in = pr_ff;
            4'd3: ub_in = pr_ff;
            4'd4: uc_in = pr_ff;
            4'd5: k0_in = pr_ff;
            4'd6: k1_in = pr_ff;
            4'd7: k2_in = pr_ff;
            4'd8: xv_in = xv_ff + (SW+4)'(3) * (SW+4)'(pr_ff);
            4'd9: xv_in = xv_ff + (SW+4)'(3) * (SW+4)'(pr_ff);
            4'd10: xv_in = xv_ff + (SW+4)'(pr_ff);
            4'd11: sv_in = sv_ff + (SW+4)'(3) * (SW+4)'(pr_ff);
            4'd12: sv_in = sv_ff + (SW+4)'(6) * (SW+4)'(pr_ff);
            4'd13: begin
               sv_in = sv_ff + (SW+4)'(3) * (SW+4)'(pr_ff);
               ev_busy_in = 1'b0;
            end
            default: ;
         endcase
         // ua/ub/uc held u,v,w until k products formed; reuse for slope after
      end
   end

   // ua=u (set step2), ub=v (step3), uc=w (step4); k0=u*t, k1=v*t, k2=w*t

   logic eval_done_ff, eval_done_in;
   assign eval_done_in = ev_busy_ff && ev_step_ff == 4'd13;

   // serial restoring divider: |err| << FRAC_BITS / |slope|
   logic div_busy_ff, div_busy_in, div_done_ff, div_done_in, qneg_ff, qneg_in;
   logic [DW-1:0] rem_ff, rem_in, quo_ff, quo_in;
   logic [DW-1:0] dvs_ff, dvs_in;
   logic [DCW-1:0] dcnt_ff, dcnt_in;
   logic signed [SW+3:0] err;

   assign err = xv_ff - (SW+4)'(p_ff);

   always_comb begin
      logic [DW-1:0] ae, as;
      logic [DW:0] r2;
      ae = err[SW+3] ? DW'(-err) : DW'(err);
      as = sv_ff[SW+3] ? DW'(-sv_ff) : DW'(sv_ff);
      div_busy_in = div_busy_ff;
      div_done_in = 1'b0;
      rem_in = rem_ff; quo_in = quo_ff; dvs_in = dvs_ff;
      dcnt_in = dcnt_ff; qneg_in = qneg_ff;
      r2 = '0;
      if (cmd.div_start) begin
         div_busy_in = 1'b1;
         quo_in = ae << FRAC_BITS;
         rem_in = '0;
         dvs_in = as;
         dcnt_in = DCW'(DW);
         qneg_in = err[SW+3] ^ sv_ff[SW+3];
      end else if (div_busy_ff) begin
         r2 = {rem_ff, quo_ff[DW-1]};
         if (r2 >= {1'b0, dvs_ff}) begin
            rem_in = DW'(r2 - {1'b0, dvs_ff});
            quo_in = {quo_ff[DW-2:0], 1'b1};
         end else begin
            rem_in = DW'(r2);
            quo_in = {quo_ff[DW-2:0], 1'b0};
         end
         dcnt_in = dcnt_ff - DCW'(1);
         if (dcnt_ff == DCW'(1)) begin
            div_busy_in = 1'b0;
            div_done_in = 1'b1;
         end
      end
   end

   // t, lo, hi updates
   always_comb begin
      logic signed [DW:0] q, tn;
      logic signed [SW+3:0] mid;
      q = qneg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
      tn = (DW+1)'(t_ff) - q;
      t_in = t_ff; lo_in = lo_ff; hi_in = hi_ff;
      mid = '0;
      if (cmd.load) begin
         t_in = p_in; lo_in = '0; hi_in = ONE;
      end else if (cmd.newton_upd) begin
         if (tn < 0) t_in = '0;
         else if (tn > (DW+1)'(ONE)) t_in = ONE;
         else t_in = SW'(tn);
      end else if (cmd.bisect_upd) begin
         if (xv_ff < (SW+4)'(p_ff)) begin
            lo_in = t_ff;
            mid = ((SW+4)'(t_ff) + (SW+4)'(hi_ff)) >>> 1;
         end else begin
            hi_in = t_ff;
            mid = ((SW+4)'(lo_ff) + (SW+4)'(t_ff)) >>> 1;
         end
         t_in = SW'(mid);
      end
   end

   logic [W-1:0] res_ff, res_in;
   always_comb begin
      res_in = res_ff;
      if (cmd.final_load) begin
         if (linear_ff) res_in = W'(p_ff);
         else if (xv_ff < 0) res_in = '0;
         else if (xv_ff > (SW+4)'(ONE)) res_in = W'(ONE);
         else res_in = W'(xv_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ev_busy_ff <= 1'b0;
         div_busy_ff <= 1'b0;
         eval_done_ff <= 1'b0;
         div_done_ff <= 1'b0;
         ev_step_ff <= '0;
      end else begin
         ev_busy_ff <= ev_busy_in;
         div_busy_ff <= div_busy_in;
         eval_done_ff <= eval_done_in;
         div_done_ff <= div_done_in;
         ev_step_ff <= ev_step_in;
      end
      if (cmd.load) begin
         x1_ff <= x1_in; x2_ff <= x2_in; p_ff <= p_in; linear_ff <= linear_in;
      end
      t_ff <= t_in; lo_ff <= lo_in; hi_ff <= hi_in;
      ev_y_ff <= ev_y_in; inv_ff <= inv_in;
      ua_ff <= ua_in; ub_ff <= ub_in; uc_ff <= uc_in;
      k0_ff <= k0_in; k1_ff <= k1_in; k2_ff <= k2_in;
      pr_ff <= pr_in; xv_ff <= xv_in; sv_ff <= sv_in;
      rem_ff <= rem_in; quo_ff <= quo_in; dvs_ff <= dvs_in;
      dcnt_ff <= dcnt_in; qneg_ff <= qneg_in;
      res_ff <= res_in;
   end

   assign sts.linear = linear_ff;
   assign sts.eval_done = eval_done_ff;
   assign sts.div_done = div_done_ff;
   assign sts.slope_flat = (sv_ff > -(SW+4)'(1)) && (sv_ff < (SW+4)'(1));
   assign sts.hit = (err > -(SW+4)'(1)) && (err < (SW+4)'(1));
   assign result = res_ff;
endmodule

// ----- src/cbe_ctrl.sv -----
// controller: sequences newton steps, bisection steps and the final evaluation
module cbe_ctrl #(
   parameter int NEWTON_STEPS = 6,
   parameter int BISECT_STEPS = 8
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   output logic rsp_valid,
   input  logic rsp_ready,
   input  cbe_pkg::sts_type sts,
   output cbe_pkg::cmd_type cmd
);
   localparam int CW = $clog2(NEWTON_STEPS + BISECT_STEPS + 1);

   cbe_pkg::state_type state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic phase_ff, phase_in;   // 0 newton, 1 bisection
   logic rv_ff, rv_in;
   // evaluation restarts once t settles after an update
   logic restart_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      phase_in = phase_ff;
      rv_in = rv_ff;
      if (rv_ff && rsp_ready) rv_in = 1'b0;
      unique case (state_ff)
         cbe_pkg::ST_IDLE: if (req_valid) state_in = cbe_pkg::ST_START;
         cbe_pkg::ST_START: begin
            cnt_in = '0;
            phase_in = 1'b0;
            state_in = sts.linear ? cbe_pkg::ST_DONE : cbe_pkg::ST_EVAL;
         end
         cbe_pkg::ST_EVAL: if (sts.eval_done) begin
            if (phase_ff) state_in = cbe_pkg::ST_BISECT_CHK;
            else if (cnt_ff == CW'(NEWTON_STEPS)) begin
               phase_in = 1'b1; cnt_in = '0;
               state_in = cbe_pkg::ST_BISECT_CHK;
            end else state_in = cbe_pkg::ST_NEWTON_CHK;
         end
         cbe_pkg::ST_NEWTON_CHK: begin
            if (sts.slope_flat) begin
               phase_in = 1'b1; cnt_in = '0;
               state_in = cbe_pkg::ST_BISECT_CHK;
            end else state_in = cbe_pkg::ST_DIVIDE;
         end
         cbe_pkg::ST_DIVIDE: if (sts.div_done) state_in = cbe_pkg::ST_NEWTON_UPD;
         cbe_pkg::ST_NEWTON_UPD: begin
            cnt_in = cnt_ff + CW'(1);
            state_in = cbe_pkg::ST_EVAL;
         end
         cbe_pkg::ST_BISECT_CHK: begin
            if (sts.hit || cnt_ff == CW'(BISECT_STEPS)) state_in = cbe_pkg::ST_FINAL;
            else begin
               cnt_in = cnt_ff + CW'(1);
               state_in = cbe_pkg::ST_EVAL;
            end
         end
         cbe_pkg::ST_FINAL: if (sts.eval_done) state_in = cbe_pkg::ST_DONE;
         cbe_pkg::ST_DONE: begin
            // the output register frees up once its word is taken
            if (!rv_ff || rsp_ready) begin
               rv_in = 1'b1;
               state_in = cbe_pkg::ST_IDLE;
            end
         end
         default: state_in = cbe_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         cbe_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load = req_valid;
         end
         cbe_pkg::ST_START: cmd.eval_start = !sts.linear;
         cbe_pkg::ST_EVAL: cmd.eval_start = restart_ff;
         cbe_pkg::ST_NEWTON_CHK: cmd.div_start = !sts.slope_flat;
         cbe_pkg::ST_DIVIDE: ;
         cbe_pkg::ST_NEWTON_UPD: cmd.newton_upd = 1'b1;
         cbe_pkg::ST_BISECT_CHK: begin
            if (sts.hit || cnt_ff == CW'(BISECT_STEPS)) begin
               cmd.eval_start = 1'b1;
               cmd.eval_y = 1'b1;
            end else cmd.bisect_upd = 1'b1;
         end
         cbe_pkg::ST_FINAL: ;
         cbe_pkg::ST_DONE: cmd.final_load = !rv_ff || rsp_ready;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cbe_pkg::ST_IDLE;
         rv_ff <= 1'b0;
         cnt_ff <= '0;
         phase_ff <= 1'b0;
         restart_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff <= rv_in;
         cnt_ff <= cnt_in;
         phase_ff <= phase_in;
         restart_ff <= cmd.newton_upd || cmd.bisect_upd;
      end
   end

   assign rsp_valid = rv_ff;
endmodule
